### rtl/mmked_pkg.sv
// ----------------------------------------------------------------------------
// mmked_pkg
// Types and constants shared by the key event detector modules.
// ----------------------------------------------------------------------------
package mmked_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned TickW  = 12;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [ModeW-1:0] {
    MODE_LEVEL   = 3'd0,
    MODE_PRESS   = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_LONG    = 3'd3,
    MODE_MULTI   = 3'd4,
    MODE_REPEAT  = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE_SELECT = 2'd0,
    CFG_TICK_LIMIT  = 2'd1,
    CFG_HOLD_FLAG   = 2'd2,
    CFG_MAX_COUNT   = 2'd3
  } cfg_idx_e;

  // Result codes that are not a press count
  localparam logic [CountW-1:0] RES_NONE  = 7'd0;
  localparam logic [CountW-1:0] RES_EDGE  = 7'd1;
  localparam logic [CountW-1:0] RES_SHORT = 7'd1;
  localparam logic [CountW-1:0] RES_LONG  = 7'd2;

  typedef struct packed {
    logic [ModeW-1:0]  mode_select;
    logic [TickW-1:0]  tick_limit;
    logic              hold_flag;
    logic [CountW-1:0] max_count;
  } cfg_t;

  typedef struct packed {
    logic              armed;
    logic [TickW-1:0]  tick_count;
    logic [CountW-1:0] press_count;
  } key_state_t;

endpackage

### rtl/mmked_tick_if.sv
// ----------------------------------------------------------------------------
// mmked_tick_if
// Valid/ready channel carrying one scan tick (key level).
// ----------------------------------------------------------------------------
interface mmked_tick_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink   (input valid, input pressed, output ready);
endinterface

### rtl/mmked_result_if.sv
// ----------------------------------------------------------------------------
// mmked_result_if
// Valid/ready channel carrying one key result per scan tick.
// ----------------------------------------------------------------------------
interface mmked_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_result;

  modport source (output valid, output key_result, input ready);
  modport sink   (input valid, input key_result, output ready);
endinterface

### rtl/mmked_cfg_regs.sv
// ----------------------------------------------------------------------------
// mmked_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mmked_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmked_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mmked_pkg::CfgDataW-1:0]  cfg_data_i,
  output mmked_pkg::cfg_t                 cfg_o
);
  import mmked_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE_SELECT: cfg_d.mode_select = cfg_data_i[ModeW-1:0];
        CFG_TICK_LIMIT:  cfg_d.tick_limit  = cfg_data_i[TickW-1:0];
        CFG_HOLD_FLAG:   cfg_d.hold_flag   = cfg_data_i[0];
        CFG_MAX_COUNT:   cfg_d.max_count   = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/mmked_event_logic.sv
// ----------------------------------------------------------------------------
// mmked_event_logic
// Per-tick next-state and result logic for all six detector modes.
// ----------------------------------------------------------------------------
module mmked_event_logic (
  input  mmked_pkg::cfg_t                 cfg_i,
  input  mmked_pkg::key_state_t           state_i,
  input  logic                            pressed_i,
  output mmked_pkg::key_state_t           state_o,
  output logic [mmked_pkg::CountW-1:0]    key_result_o
);
  import mmked_pkg::*;

  logic [TickW-1:0]  tick_inc;
  logic [CountW-1:0] press_inc;
  logic              armed_m;
  logic [TickW-1:0]  tick_m;
  logic [CountW-1:0] press_m;

  assign tick_inc  = state_i.tick_count + TickW'(1);
  assign press_inc = state_i.press_count + CountW'(1);

  always_comb begin
    state_o      = state_i;
    key_result_o = RES_NONE;
    armed_m      = state_i.armed;
    tick_m       = state_i.tick_count;
    press_m      = state_i.press_count;

    case (mode_e'(cfg_i.mode_select))
      MODE_LEVEL: begin
        key_result_o = {{(CountW-1){1'b0}}, pressed_i};
      end
      MODE_PRESS: begin
        if (pressed_i && state_i.armed) begin
          state_o.armed = 1'b0;
          key_result_o  = RES_EDGE;
        end else if (!pressed_i) begin
          state_o.armed = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (pressed_i) begin
          state_o.armed = 1'b1;
        end else if (state_i.armed) begin
          state_o.armed = 1'b0;
          key_result_o  = RES_EDGE;
        end
      end
      MODE_LONG: begin
        if (pressed_i) begin
          if (state_i.tick_count < cfg_i.tick_limit) begin
            state_o.tick_count = tick_inc;
          end else if (cfg_i.hold_flag || state_i.armed) begin
            state_o.armed = 1'b0;
            key_result_o  = RES_LONG;
          end
        end else begin
          if ((state_i.tick_count != '0) && (state_i.tick_count < cfg_i.tick_limit)) begin
            key_result_o = RES_SHORT;
          end
          state_o.armed      = 1'b1;
          state_o.tick_count = '0;
        end
      end
      MODE_MULTI: begin
        // Count the press first, then check the end of the burst
        if (pressed_i && state_i.armed) begin
          tick_m  = '0;
          armed_m = 1'b0;
          press_m = press_inc;
        end else if (!pressed_i) begin
          armed_m = 1'b1;
        end
        if ((tick_m >= cfg_i.tick_limit) || (press_m == cfg_i.max_count)) begin
          key_result_o = press_m;
          state_o      = '0;
        end else begin
          state_o.armed       = armed_m;
          state_o.tick_count  = tick_m + TickW'(1);
          state_o.press_count = press_m;
        end
      end
      MODE_REPEAT: begin
        if (pressed_i) begin
          press_m             = state_i.armed ? press_inc : state_i.press_count;
          state_o.press_count = press_m;
          state_o.tick_count  = '0;
          state_o.armed       = 1'b0;
          key_result_o        = press_m;
        end else begin
          state_o.armed = 1'b1;
          if ((state_i.tick_count < cfg_i.tick_limit) &&
              (state_i.press_count < cfg_i.max_count)) begin
            state_o.tick_count = tick_inc;
          end else begin
            state_o.press_count = '0;
          end
          key_result_o = cfg_i.hold_flag ? state_o.press_count : RES_NONE;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/multi_mode_key_event_detector_core.sv
// ----------------------------------------------------------------------------
// multi_mode_key_event_detector_core
// Key event detector: level, press/release edge, long press, multi click and
// fast repeat, one result per scan tick.
// ----------------------------------------------------------------------------
//
//   channel     | dir | payload            | transfer when
//   ------------+-----+--------------------+---------------------------
//   tick_in     | in  | pressed (1 bit)    | valid && ready
//   result_out  | out | key_result (7 bit) | valid && ready
//   cfg         | in  | index 2b, data 12b | cfg_we_i
//
// A tick passes through the input register and then the result register; a
// stall on result_out can hold it in between. One tick enters per cycle as
// long as the result side keeps taking results; the per-tick state update is
// a single pass of compares, increments and the mode mux.
// Reset clears the configuration, the detector state and both valid flags.
// A stall on result_out holds the result register and, once the input
// register is also full, drops tick_in.ready.
// ----------------------------------------------------------------------------
module multi_mode_key_event_detector_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmked_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mmked_pkg::CfgDataW-1:0]  cfg_data_i,
  mmked_tick_if.sink                      tick_in,
  mmked_result_if.source                  result_out
);
  import mmked_pkg::*;

  cfg_t              cfg;
  key_state_t        state_q;
  key_state_t        state_d;
  logic [CountW-1:0] result_d;
  logic [CountW-1:0] result_q;

  logic in_valid_q;
  logic pressed_q;
  logic out_valid_q;
  logic advance;
  logic in_ready;

  // Configuration registers
  mmked_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register moves whenever it is empty or being drained
  assign advance  = !out_valid_q || result_out.ready;
  // Input register takes a tick when empty or when its tick moves on
  assign in_ready = !in_valid_q || advance;
  assign tick_in.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= tick_in.valid;
    end
  end

  // Hold the tick level; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready && tick_in.valid) begin
      pressed_q <= tick_in.pressed;
    end
  end

  // Per-tick detector logic between the input and result registers
  mmked_event_logic u_event_logic (
    .cfg_i        (cfg),
    .state_i      (state_q),
    .pressed_i    (pressed_q),
    .state_o      (state_d),
    .key_result_o (result_d)
  );

  // Commit the detector state only when the tick actually moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_out.valid      = out_valid_q;
  assign result_out.key_result = result_q;

endmodule
